// File: rtl/ils_pkg.sv
package ils_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND    = 3'd0,
    MODE_INSERT    = 3'd1,
    MODE_OVERWRITE = 3'd2,
    MODE_READ      = 3'd3,
    MODE_REMOVE    = 3'd4,
    MODE_FIND      = 3'd5,
    MODE_CLEAR     = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_POS = 2'd1,
    STAT_NULL    = 2'd2,
    STAT_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    mode_t       mode;
    logic [6:0]  position;
    logic [31:0] element;
  } ils_req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] data_out;
    logic        found;
    logic [5:0]  found_position;
    logic [6:0]  count;
  } ils_result_t;

  typedef enum logic [1:0] {
    RD_POS,
    RD_IDX,
    RD_IDX_DN,
    RD_IDX_UP
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_COUNT,
    WR_POS,
    WR_IDX
  } wr_sel_t;

  typedef enum logic {
    WSRC_ELEM,
    WSRC_RD
  } wr_src_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_LOAD_COUNT,
    IDX_LOAD_POS,
    IDX_LOAD_ZERO,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef struct packed {
    logic    latch;
    logic    set_status;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    wr_sel_t wr_sel;
    wr_src_t wr_src;
    cnt_op_t cnt_op;
    idx_op_t idx_op;
    logic    cap_data;
    logic    set_found;
  } ils_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  status_ok;
    logic  idx_eq_pos;
    logic  idx_last;
    logic  idx_end;
    logic  match;
  } ils_stat_t;

endpackage

// File: rtl/ils_datapath.sv
module ils_datapath #(
  parameter int CAPACITY     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ils_pkg::ils_req_t    request,
  input  ils_pkg::ils_cmd_t    cmd,
  output ils_pkg::ils_stat_t   stat,
  output ils_pkg::ils_result_t result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;

  logic [ELEMENT_BITS-1:0] mem [CAPACITY];
  logic [ELEMENT_BITS-1:0] rd_data;
  logic [ELEMENT_BITS-1:0] wr_data;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           wr_addr;

  ils_pkg::mode_t          req_mode;
  logic [PW-1:0]           req_pos;
  logic [ELEMENT_BITS-1:0] req_elem;
  logic [CW-1:0]           count;
  logic [CW-1:0]           idx;
  logic [CW-1:0]           idx_dn;
  logic [CW-1:0]           idx_up;
  logic [PW-1:0]           idx_w;
  logic [PW-1:0]           count_w;
  logic [63:0]             elem_wide;
  logic [63:0]             data_wide;
  logic [PW-1:0]           fpos_wide;

  ils_pkg::status_t        status_reg;
  ils_pkg::status_t        status_calc;
  logic [ELEMENT_BITS-1:0] data_reg;
  logic                    found_reg;
  logic [AW-1:0]           fpos_reg;

  logic                    elem_null;
  logic                    full;
  logic                    pos_gt_count;
  logic                    pos_ge_count;

  assign elem_wide = {32'd0, request.element};
  assign idx_dn    = idx - CW'(1);
  assign idx_up    = idx + CW'(1);
  assign idx_w     = PW'(idx);
  assign count_w   = PW'(count);

  assign elem_null    = (req_elem == '0);
  assign full         = (count == CW'(CAPACITY));
  assign pos_gt_count = (req_pos > count_w);
  assign pos_ge_count = (req_pos >= count_w);

  always_comb begin
    status_calc = ils_pkg::STAT_OK;
    unique case (req_mode)
      ils_pkg::MODE_APPEND: begin
        if (elem_null) status_calc = ils_pkg::STAT_NULL;
        else if (full) status_calc = ils_pkg::STAT_FULL;
      end
      ils_pkg::MODE_INSERT: begin
        if (elem_null) status_calc = ils_pkg::STAT_NULL;
        else if (pos_gt_count) status_calc = ils_pkg::STAT_BAD_POS;
        else if (full) status_calc = ils_pkg::STAT_FULL;
      end
      ils_pkg::MODE_OVERWRITE: begin
        if (elem_null) status_calc = ils_pkg::STAT_NULL;
        else if (pos_ge_count) status_calc = ils_pkg::STAT_BAD_POS;
      end
      ils_pkg::MODE_READ, ils_pkg::MODE_REMOVE: begin
        if (pos_ge_count) status_calc = ils_pkg::STAT_BAD_POS;
      end
      ils_pkg::MODE_FIND: begin
        if (elem_null) status_calc = ils_pkg::STAT_NULL;
      end
      default: status_calc = ils_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    case (cmd.rd_sel)
      ils_pkg::RD_POS:    rd_addr = req_pos[AW-1:0];
      ils_pkg::RD_IDX_DN: rd_addr = idx_dn[AW-1:0];
      ils_pkg::RD_IDX_UP: rd_addr = idx_up[AW-1:0];
      default:            rd_addr = idx[AW-1:0];
    endcase
    case (cmd.wr_sel)
      ils_pkg::WR_COUNT: wr_addr = count[AW-1:0];
      ils_pkg::WR_POS:   wr_addr = req_pos[AW-1:0];
      default:           wr_addr = idx[AW-1:0];
    endcase
    wr_data = (cmd.wr_src == ils_pkg::WSRC_RD) ? rd_data : req_elem;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        ils_pkg::CNT_INC: count <= count + CW'(1);
        ils_pkg::CNT_DEC: count <= count - CW'(1);
        ils_pkg::CNT_CLR: count <= '0;
        default:          count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.idx_op)
      ils_pkg::IDX_LOAD_COUNT: idx <= count;
      ils_pkg::IDX_LOAD_POS:   idx <= req_pos[CW-1:0];
      ils_pkg::IDX_LOAD_ZERO:  idx <= '0;
      ils_pkg::IDX_INC:        idx <= idx_up;
      ils_pkg::IDX_DEC:        idx <= idx_dn;
      default:                 idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_mode  <= request.mode;
      req_pos   <= PW'(request.position);
      req_elem  <= elem_wide[ELEMENT_BITS-1:0];
      data_reg  <= '0;
      found_reg <= 1'b0;
      fpos_reg  <= '0;
    end else begin
      if (cmd.cap_data) begin
        data_reg <= rd_data;
      end
      if (cmd.set_found) begin
        found_reg <= 1'b1;
        fpos_reg  <= idx[AW-1:0];
      end
    end
    if (cmd.set_status) begin
      status_reg <= status_calc;
    end
  end

  assign stat.mode       = req_mode;
  assign stat.status_ok  = (status_calc == ils_pkg::STAT_OK);
  assign stat.idx_eq_pos = (idx_w == req_pos);
  assign stat.idx_last   = ({1'b0, idx} + {{CW{1'b0}}, 1'b1}) >= {1'b0, count};
  assign stat.idx_end    = (idx >= count);
  assign stat.match      = (rd_data == req_elem);

  assign data_wide = 64'(data_reg);
  assign fpos_wide = PW'(fpos_reg);

  assign result.status         = status_reg;
  assign result.data_out       = data_wide[31:0];
  assign result.found          = found_reg;
  assign result.found_position = fpos_wide[5:0];
  assign result.count          = count_w[6:0];

endmodule

// File: rtl/ils_ctrl.sv
module ils_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ils_pkg::ils_stat_t stat,
  output ils_pkg::ils_cmd_t  cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_RD_WAIT,
    ST_SU_RD,
    ST_SU_WR,
    ST_RM_CAP,
    ST_SD_RD,
    ST_SD_WR,
    ST_SC_RD,
    ST_SC_CMP
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;

  always_comb begin
    cmd        = '0;
    finish     = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.set_status = 1'b1;
        if (!stat.status_ok) begin
          finish = 1'b1;
        end else begin
          unique case (stat.mode)
            ils_pkg::MODE_APPEND: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ils_pkg::WR_COUNT;
              cmd.cnt_op = ils_pkg::CNT_INC;
              finish     = 1'b1;
            end
            ils_pkg::MODE_INSERT: begin
              cmd.idx_op = ils_pkg::IDX_LOAD_COUNT;
              state_next = ST_SU_RD;
            end
            ils_pkg::MODE_OVERWRITE: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ils_pkg::WR_POS;
              finish     = 1'b1;
            end
            ils_pkg::MODE_READ: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ils_pkg::RD_POS;
              state_next = ST_RD_WAIT;
            end
            ils_pkg::MODE_REMOVE: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ils_pkg::RD_POS;
              cmd.idx_op = ils_pkg::IDX_LOAD_POS;
              state_next = ST_RM_CAP;
            end
            ils_pkg::MODE_FIND: begin
              cmd.idx_op = ils_pkg::IDX_LOAD_ZERO;
              state_next = ST_SC_RD;
            end
            ils_pkg::MODE_CLEAR: begin
              cmd.cnt_op = ils_pkg::CNT_CLR;
              finish     = 1'b1;
            end
            default: finish = 1'b1;
          endcase
        end
      end
      ST_RD_WAIT: begin
        cmd.cap_data = 1'b1;
        finish       = 1'b1;
      end
      // shift up from the tail, then drop the new word into the gap
      ST_SU_RD: begin
        if (stat.idx_eq_pos) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ils_pkg::WR_IDX;
          cmd.cnt_op = ils_pkg::CNT_INC;
          finish     = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_IDX_DN;
          state_next = ST_SU_WR;
        end
      end
      ST_SU_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ils_pkg::WR_IDX;
        cmd.wr_src = ils_pkg::WSRC_RD;
        cmd.idx_op = ils_pkg::IDX_DEC;
        state_next = ST_SU_RD;
      end
      ST_RM_CAP: begin
        cmd.cap_data = 1'b1;
        state_next   = ST_SD_RD;
      end
      // close the gap left by the removed word
      ST_SD_RD: begin
        if (stat.idx_last) begin
          cmd.cnt_op = ils_pkg::CNT_DEC;
          finish     = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_IDX_UP;
          state_next = ST_SD_WR;
        end
      end
      ST_SD_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ils_pkg::WR_IDX;
        cmd.wr_src = ils_pkg::WSRC_RD;
        cmd.idx_op = ils_pkg::IDX_INC;
        state_next = ST_SD_RD;
      end
      ST_SC_RD: begin
        if (stat.idx_end) begin
          finish = 1'b1;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ils_pkg::RD_IDX;
          state_next = ST_SC_CMP;
        end
      end
      ST_SC_CMP: begin
        if (stat.match) begin
          cmd.set_found = 1'b1;
          finish        = 1'b1;
        end else begin
          cmd.idx_op = ils_pkg::IDX_INC;
          state_next = ST_SC_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (finish) begin
      state_next = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= finish;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/indexed_list_store_core.sv
// Ordered list of up to CAPACITY words held in a single-port-style memory
// (one write, one registered read per cycle). A request is taken when start
// is high and busy is low; its result shows on result for exactly one cycle
// with done high, and must be captured then since the block cannot be
// stalled. Append, overwrite, clear and any rejected request finish in the
// decide state; read waits for its registered memory word. Insert, remove
// and find step through the list: insert reads each entry from the tail
// down to position and writes it one place up, remove moves each entry above
// position one place down, and find reads and compares entries from position
// 0 until a hit or the list end. busy is already low in the done cycle, so
// the next request may be issued there. No clearing pass is needed after reset.
module indexed_list_store_core #(
  parameter int CAPACITY     = 64,
  parameter int ELEMENT_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  ils_pkg::ils_req_t    request,
  output logic                 done,
  output ils_pkg::ils_result_t result
);

  ils_pkg::ils_cmd_t  cmd;
  ils_pkg::ils_stat_t stat;

  ils_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ils_datapath #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result)
  );

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done raised while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_done_after_work: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done without a request in flight");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != ils_pkg::STAT_OK) |->
      (result.data_out == 32'd0 && !result.found))
    else $error("rejected request returned data");

endmodule
